FILE: rtl/core/mabm_pkg.sv
// ----------------------------------------------------------------------------
// Moving-average bar meter package
// Shared widths, constants, state type and bar decoding for the meter core.
// ----------------------------------------------------------------------------
package mabm_pkg;

    localparam int SAMPLE_W        = 10;   // raw, scaled and average width
    localparam int BAR_LAMPS       = 10;
    localparam int FULL_SCALE      = 1023;
    localparam int SCALE_SPAN      = FULL_SCALE - 1;
    localparam int MIN_LIMIT       = 2;
    localparam int SENSE_RESET     = 1023;
    localparam int BAR_FIRST       = 50;
    localparam int BAR_STEP        = 100;
    localparam int DEF_WINDOW_LEN  = 25;

    // Rescale divider: 20-bit dividend, 10-bit divisor, 10 quotient bits
    localparam int DIV_W           = 20;
    localparam int QUO_W           = 10;
    localparam int CNT_W           = $clog2(QUO_W);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV_SCALE,
        ST_UPDATE,
        ST_AVG,
        ST_OUT
    } t_state;

    // Thermometer bar: lamp k lit when the average exceeds 50 + 100k
    function automatic logic [BAR_LAMPS-1:0] bar_of(input logic [SAMPLE_W-1:0] avg);
        logic [BAR_LAMPS-1:0] bar;
        bar = '0;
        for (int k = 0; k < BAR_LAMPS; k++) begin
            bar[k] = (int'(avg) > BAR_FIRST + BAR_STEP * k);
        end
        return bar;
    endfunction

endpackage

FILE: rtl/core/mabm_if.sv
// ----------------------------------------------------------------------------
// Moving-average bar meter channels
// Valid/ready interfaces for the sample, result and configuration channels.
// ----------------------------------------------------------------------------
interface mabm_sample_if import mabm_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] raw_sample;

    modport source (output valid, output raw_sample, input ready);
    modport sink   (input valid, input raw_sample, output ready);
endinterface

interface mabm_result_if import mabm_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [SAMPLE_W-1:0]  scaled_sample;
    logic [SAMPLE_W-1:0]  window_average;
    logic [BAR_LAMPS-1:0] bar_lamps;

    modport source (output valid, output scaled_sample, output window_average,
                    output bar_lamps, input ready);
    modport sink   (input valid, input scaled_sample, input window_average,
                    input bar_lamps, output ready);
endinterface

interface mabm_cfg_if import mabm_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/core/mabm_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module mabm_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 25
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/moving_average_bar_meter_core.sv
// ----------------------------------------------------------------------------
// Moving-average bar meter core
// Clamps and rescales converter samples, keeps a windowed running mean and
// drives a thermometer bar from it.
// ----------------------------------------------------------------------------
// Usage:
//   i_sample carries one raw converter reading per item. A reading of zero is
//   taken and dropped: it gives no result and leaves the window untouched.
//   Every other reading yields one item on o_result: the rescaled sample,
//   the window average and the 10-lamp bar.
//   i_cfg writes sense_limit and is always ready; the user must write it
//   only while idle, since the core itself does not enforce this.
// Sequence:
//   A nonzero item passes through the multiply, the 10-step restoring
//   divider for the rescale, the window update, the average and the output
//   states; the next item is accepted only once the core is back in idle.
//   The average divides by the window length through a reciprocal multiply.
//   A zero reading is taken without the core leaving idle.
// Reset:
//   sense_limit returns to 1023, the slot pointer and running total clear
//   and all window entries read as zero through per-entry valid flags.
// Stall:
//   The result sits in an output register; the core keeps working on the
//   next item and holds in its final step until the register is free.
// ----------------------------------------------------------------------------
module moving_average_bar_meter_core import mabm_pkg::*; #(
    parameter int WINDOW_LEN = DEF_WINDOW_LEN
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    mabm_sample_if.sink   i_sample,
    mabm_cfg_if.sink      i_cfg,
    mabm_result_if.source o_result
);

    localparam int SLOT_W  = $clog2(WINDOW_LEN);
    localparam int TOTAL_W = $clog2(WINDOW_LEN * FULL_SCALE + 1);
    // Reciprocal of the window length, exact for every total below 2**TOTAL_W
    localparam int     RECIP_SHIFT = TOTAL_W + SLOT_W;
    localparam longint RECIP       = ((longint'(1) << RECIP_SHIFT) + WINDOW_LEN - 1)
                                     / WINDOW_LEN;
    localparam int     PROD_W      = 2 * TOTAL_W + 1;

    // Control
    t_state                r_state, n_state;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic [SLOT_W-1:0]     r_slot, n_slot;
    logic [WINDOW_LEN-1:0] r_valid, n_valid;
    logic [TOTAL_W-1:0]    r_total, n_total;
    logic [SAMPLE_W-1:0]   r_sense_limit;
    logic                  r_out_valid;

    // Datapath
    logic [SAMPLE_W-1:0]   r_num_a, n_num_a;
    logic [SAMPLE_W-1:0]   r_div, n_div;
    logic [DIV_W-1:0]      r_rem, n_rem;
    logic [QUO_W-1:0]      r_q, n_q;
    logic [SAMPLE_W-1:0]   r_old, n_old;
    logic [SAMPLE_W-1:0]   r_scaled, n_scaled;
    logic [SAMPLE_W-1:0]   r_avg, n_avg;
    logic [SAMPLE_W-1:0]   r_out_scaled;
    logic [SAMPLE_W-1:0]   r_out_avg;
    logic [BAR_LAMPS-1:0]  r_out_bar;

    // Helpers
    logic                  sample_acc;
    logic                  out_load;
    logic [SAMPLE_W-1:0]   limit;
    logic [SAMPLE_W-1:0]   clamped;
    logic [DIV_W-1:0]      shifted;
    logic                  ge;
    logic [QUO_W-1:0]      q_step;
    logic [DIV_W-1:0]      rem_step;
    logic [PROD_W-1:0]     avg_prod;
    logic                  ram_we;
    logic                  ram_re;
    logic [SAMPLE_W-1:0]   ram_rdata;

    assign i_sample.ready = (r_state == ST_IDLE);
    assign i_cfg.ready    = 1'b1;
    assign sample_acc     = i_sample.valid && i_sample.ready;

    // Saturate the limit, then clamp the reading into [1, limit]
    assign limit   = (r_sense_limit < SAMPLE_W'(MIN_LIMIT)) ? SAMPLE_W'(MIN_LIMIT)
                                                            : r_sense_limit;
    assign clamped = (i_sample.raw_sample > limit) ? limit : i_sample.raw_sample;

    // One restoring division step, quotient bit r_cnt
    assign shifted  = DIV_W'(r_div) << r_cnt;
    assign ge       = (r_rem >= shifted);
    assign rem_step = ge ? (r_rem - shifted) : r_rem;
    assign q_step   = {r_q[QUO_W-2:0], ge};

    // Average as total times the reciprocal of the window length
    assign avg_prod = PROD_W'(r_total) * PROD_W'(RECIP);

    // Read the slot about to be overwritten as the item is taken
    assign ram_re = sample_acc;
    assign ram_we = (r_state == ST_UPDATE);

    mabm_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (WINDOW_LEN)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_slot),
        .i_wdata (r_scaled),
        .i_re    (ram_re),
        .i_raddr (r_slot),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_slot   = r_slot;
        n_valid  = r_valid;
        n_total  = r_total;
        n_num_a  = r_num_a;
        n_div    = r_div;
        n_rem    = r_rem;
        n_q      = r_q;
        n_old    = r_old;
        n_scaled = r_scaled;
        n_avg    = r_avg;
        out_load = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (sample_acc && (i_sample.raw_sample != '0)) begin
                    n_num_a = clamped - SAMPLE_W'(1);
                    n_div   = limit - SAMPLE_W'(1);
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                // Register the product before the divider sees it
                n_rem   = DIV_W'(r_num_a) * DIV_W'(SCALE_SPAN);
                n_q     = '0;
                n_cnt   = CNT_W'(QUO_W - 1);
                n_old   = r_valid[r_slot] ? ram_rdata : '0;
                n_state = ST_DIV_SCALE;
            end
            ST_DIV_SCALE: begin
                n_rem = rem_step;
                n_q   = q_step;
                n_cnt = r_cnt - CNT_W'(1);
                if (r_cnt == '0) begin
                    n_scaled = q_step + SAMPLE_W'(1);
                    n_state  = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                // Retire the oldest entry, admit the new one, advance the slot
                n_total = r_total - TOTAL_W'(r_old) + TOTAL_W'(r_scaled);
                n_valid[r_slot] = 1'b1;
                n_slot  = (r_slot == SLOT_W'(WINDOW_LEN - 1)) ? '0
                                                              : r_slot + SLOT_W'(1);
                n_state = ST_AVG;
            end
            ST_AVG: begin
                n_avg   = SAMPLE_W'(avg_prod >> RECIP_SHIFT);
                n_state = ST_OUT;
            end
            ST_OUT: begin
                // Hold until the output register is free
                if (!r_out_valid || o_result.ready) begin
                    out_load = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_cnt         <= '0;
            r_slot        <= '0;
            r_valid       <= '0;
            r_total       <= '0;
            r_sense_limit <= SAMPLE_W'(SENSE_RESET);
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_slot  <= n_slot;
            r_valid <= n_valid;
            r_total <= n_total;
            if (i_cfg.valid && i_cfg.ready) begin
                r_sense_limit <= i_cfg.data;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_num_a  <= n_num_a;
        r_div    <= n_div;
        r_rem    <= n_rem;
        r_q      <= n_q;
        r_old    <= n_old;
        r_scaled <= n_scaled;
        r_avg    <= n_avg;
        if (out_load) begin
            r_out_scaled <= r_scaled;
            r_out_avg    <= r_avg;
            r_out_bar    <= bar_of(r_avg);
        end
    end

    assign o_result.valid          = r_out_valid;
    assign o_result.scaled_sample  = r_out_scaled;
    assign o_result.window_average = r_out_avg;
    assign o_result.bar_lamps      = r_out_bar;

endmodule

FILE: rtl/core/mabm_checker.sv
// ----------------------------------------------------------------------------
// Moving-average bar meter checker
// Port-level assertions for the meter core, attached by bind.
// ----------------------------------------------------------------------------
module mabm_checker import mabm_pkg::*; (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 i_in_ready,
    input logic [SAMPLE_W-1:0]  i_raw_sample,
    input logic                 i_out_valid,
    input logic                 i_out_ready,
    input logic [SAMPLE_W-1:0]  i_scaled_sample,
    input logic [SAMPLE_W-1:0]  i_window_average,
    input logic [BAR_LAMPS-1:0] i_bar_lamps
);

    // Hold a result until it is taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("result dropped while stalled");

    // A nonzero sample occupies the core for at least the next cycle
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready && (i_raw_sample != '0)) |=> !i_in_ready)
        else $error("core ready right after taking a sample");

    // Rescaled samples never fall below one
    a_scaled_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_scaled_sample != '0))
        else $error("scaled sample is zero");

    // Bar is a thermometer code matching the average at both ends
    a_bar_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (((i_bar_lamps >> 1) & ~i_bar_lamps) == '0)
                        && (i_bar_lamps[0] == (int'(i_window_average) > BAR_FIRST))
                        && (i_bar_lamps[BAR_LAMPS-1] == (int'(i_window_average) >
                            BAR_FIRST + BAR_STEP * (BAR_LAMPS - 1))))
        else $error("bar does not match average");

endmodule

bind moving_average_bar_meter_core mabm_checker u_mabm_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_sample.valid),
    .i_in_ready       (i_sample.ready),
    .i_raw_sample     (i_sample.raw_sample),
    .i_out_valid      (o_result.valid),
    .i_out_ready      (o_result.ready),
    .i_scaled_sample  (o_result.scaled_sample),
    .i_window_average (o_result.window_average),
    .i_bar_lamps      (o_result.bar_lamps)
);

FILE: sim/tb_moving_average_bar_meter_core.sv
// ----------------------------------------------------------------------------
// Moving-average bar meter core testbench
// Drives raw converter readings through the core under several sense_limit
// settings and checks every result item against a cycle-free model of the
// clamp, rescale, 25-entry window mean and lamp bar. Both channels idle at
// random; the config register is only written once the core has drained.
// ----------------------------------------------------------------------------
module tb_moving_average_bar_meter_core;
    import mabm_pkg::*;

    localparam int CLK_PERIOD     = 20;
    localparam int RESET_CYCLES   = 10;
    localparam int SETTLE_CYCLES  = 40;       // settle time after the last result
    localparam int TIMEOUT_CYCLES = 400_000;
    localparam int RANDOM_ITEMS   = 450;
    localparam int PHASES         = 8;

    typedef logic [SAMPLE_W-1:0]  sample_t;
    typedef logic [BAR_LAMPS-1:0] lamps_t;

    typedef struct packed {
        sample_t scaled;
        sample_t average;
        lamps_t  lamps;
    } meter_reading_t;

    typedef enum int {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HALF,
        STALL_HEAVY
    } stall_mode_t;

    // ------------------------------------------------------------------------
    // Scoreboard: own copy of the window state and the expected readings
    // ------------------------------------------------------------------------
    class meter_scoreboard;
        int unsigned    sense_limit;
        int unsigned    ring [DEF_WINDOW_LEN];
        int unsigned    slot;
        int unsigned    total;
        meter_reading_t expected_readings [$];
        int             error_count;
        int             samples_seen;
        int             zeros_seen;
        int             readings_checked;

        function new();
            sense_limit      = SENSE_RESET;
            foreach (ring[i]) ring[i] = 0;
            slot             = 0;
            total            = 0;
            error_count      = 0;
            samples_seen     = 0;
            zeros_seen       = 0;
            readings_checked = 0;
        endfunction

        function void write_limit(sample_t value);
            sense_limit = value;
        endfunction

        function int pending_count();
            return expected_readings.size();
        endfunction

        // Clamp, rescale and push one nonzero reading; return the meter display.
        function meter_reading_t advance_window(sample_t raw);
            int unsigned    lim;
            int unsigned    clamped;
            int unsigned    scaled;
            int unsigned    average;
            meter_reading_t reading;
            lim     = (sense_limit < MIN_LIMIT) ? MIN_LIMIT : sense_limit;
            clamped = (raw > lim) ? lim : raw;
            scaled  = (clamped - 1) * SCALE_SPAN / (lim - 1) + 1;
            total   = total - ring[slot] + scaled;
            ring[slot] = scaled;
            slot    = (slot + 1) % DEF_WINDOW_LEN;
            average = total / DEF_WINDOW_LEN;
            reading.scaled  = sample_t'(scaled);
            reading.average = sample_t'(average);
            reading.lamps   = '0;
            for (int k = 0; k < BAR_LAMPS; k++) begin
                reading.lamps[k] = (average > BAR_FIRST + BAR_STEP * k);
            end
            return reading;
        endfunction

        // Note an accepted input item; a zero reading leaves the window alone.
        function void note_sample(sample_t raw);
            samples_seen++;
            if (raw == '0) begin
                zeros_seen++;
            end else begin
                expected_readings.push_back(advance_window(raw));
            end
        endfunction

        function void check_result(sample_t scaled, sample_t average, lamps_t lamps);
            meter_reading_t want;
            if (expected_readings.size() == 0) begin
                error_count++;
                $display("%0t: unexpected result item: scaled %0d average %0d lamps %b",
                         $time, scaled, average, lamps);
                return;
            end
            want = expected_readings.pop_front();
            readings_checked++;
            if (want.scaled !== scaled) begin
                error_count++;
                $display("%0t: scaled_sample expected %0d actual %0d",
                         $time, want.scaled, scaled);
            end
            if (want.average !== average) begin
                error_count++;
                $display("%0t: window_average expected %0d actual %0d",
                         $time, want.average, average);
            end
            if (want.lamps !== lamps) begin
                error_count++;
                $display("%0t: bar_lamps expected %b actual %b",
                         $time, want.lamps, lamps);
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, channels and the core
    // ------------------------------------------------------------------------
    logic i_clk = 1'b0;
    logic i_rst_n;

    always begin
        #(CLK_PERIOD / 2) i_clk = 1'b1;
        #(CLK_PERIOD / 2) i_clk = 1'b0;
    end

    mabm_sample_if smp_if ();
    mabm_cfg_if    cfg_if ();
    mabm_result_if res_if ();

    moving_average_bar_meter_core DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_sample (smp_if),
        .i_cfg    (cfg_if),
        .o_result (res_if)
    );

    meter_scoreboard sb = new();

    int burst_left     = 0;
    int limits_written = 0;

    // ------------------------------------------------------------------------
    // Sender tasks
    // ------------------------------------------------------------------------
    // Present one item and hold it until taken; valid stays high afterwards.
    task automatic send_sample(input sample_t raw);
        smp_if.valid      <= 1'b1;
        smp_if.raw_sample <= raw;
        @(posedge i_clk);
        while (!smp_if.ready) @(posedge i_clk);
        sb.note_sample(raw);
    endtask

    // Send one item; when the burst runs out, drop valid for a random gap.
    task automatic send_paced(input sample_t raw);
        int gap;
        send_sample(raw);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
            gap = $urandom_range(0, 30);
            if (gap > 0) begin
                smp_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // Hold the sender until every expected result is out, then let the core settle.
    task automatic drain_results();
        smp_if.valid <= 1'b0;
        while (sb.pending_count() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_sense_limit(input sample_t value);
        drain_results();
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= value;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        sb.write_limit(value);
        cfg_if.valid <= 1'b0;
        limits_written++;
    endtask

    // Mix of level runs (to swing the average across the whole bar), runs at
    // the clamp point, single uniform readings and the odd zero reading.
    task automatic run_random_items(input int n_items);
        int sent;
        int kind;
        int level;
        int run_len;
        int raw;
        sent = 0;
        while (sent < n_items) begin
            kind = $urandom_range(0, 9);
            if (kind < 4) begin
                level   = (kind == 0) ? int'(sb.sense_limit) : $urandom_range(1, 1023);
                run_len = $urandom_range(5, 30);
            end else begin
                level   = -1;
                run_len = 1;
            end
            repeat (run_len) begin
                if (sent >= n_items) break;
                if (level < 0) begin
                    raw = (kind == 9) ? 0 : $urandom_range(0, 1023);
                end else begin
                    raw = level + int'($urandom_range(0, 16)) - 8;
                end
                if (raw < 0) raw = 0;
                if (raw > FULL_SCALE) raw = FULL_SCALE;
                send_paced(sample_t'(raw));
                if (raw != 0) sent++;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Receiver: ready follows stretches of differing stall density
    // ------------------------------------------------------------------------
    initial begin : result_stall_pattern
        stall_mode_t mode;
        int          span;
        res_if.ready <= 1'b0;
        forever begin
            mode = stall_mode_t'($urandom_range(0, 3));
            span = $urandom_range(20, 200);
            repeat (span) begin
                @(posedge i_clk);
                case (mode)
                    STALL_NONE:  res_if.ready <= 1'b1;
                    STALL_LIGHT: res_if.ready <= ($urandom_range(0, 3) != 0);
                    STALL_HALF:  res_if.ready <= ($urandom_range(0, 1) != 0);
                    default:     res_if.ready <= ($urandom_range(0, 39) == 0);
                endcase
            end
        end
    end

    // Check every accepted result item against the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready) begin
            sb.check_result(res_if.scaled_sample, res_if.window_average,
                            res_if.bar_lamps);
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin : stimulus
        sample_t opening [16];
        int      phase_limit [PHASES];
        i_rst_n           <= 1'b0;
        smp_if.valid      <= 1'b0;
        smp_if.raw_sample <= '0;
        cfg_if.valid      <= 1'b0;
        cfg_if.data       <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset limit: field extremes, a dropped zero, alternating bits and a
        // partly filled window.
        opening = '{1, 1023, 0, 512, 341, 682, 2, 1022,
                    1023, 1023, 1023, 1023, 1023, 1023, 1023, 1023};
        foreach (opening[i]) send_paced(opening[i]);

        // Smallest limit, then the two values below it that saturate to it.
        write_sense_limit(sample_t'(MIN_LIMIT));
        send_paced(1); send_paced(2); send_paced(1023);
        write_sense_limit(1);
        send_paced(1); send_paced(2); send_paced(1023);
        write_sense_limit(0);
        send_paced(1); send_paced(3); send_paced(1023);

        phase_limit = '{SENSE_RESET, MIN_LIMIT, $urandom_range(3, 1021), 1022,
                        $urandom_range(3, 1021), 3, $urandom_range(3, 1021),
                        SENSE_RESET};
        foreach (phase_limit[p]) begin
            write_sense_limit(sample_t'(phase_limit[p]));
            run_random_items(RANDOM_ITEMS / (2 * PHASES));
            // hold off mid-phase until the core has emptied
            drain_results();
            run_random_items(RANDOM_ITEMS / (2 * PHASES));
        end

        drain_results();
        $display("Covered %0d input items (%0d zero readings dropped), %0d results checked",
                 sb.samples_seen, sb.zeros_seen, sb.readings_checked);
        $display("across %0d sense_limit writes including the saturating values 0 and 1.",
                 limits_written);
        if (sb.error_count == 0 && sb.pending_count() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin : watchdog
        #(CLK_PERIOD * TIMEOUT_CYCLES);
        $display("Timed out with %0d results outstanding", sb.pending_count());
        $display("FAILURE");
        $finish;
    end

endmodule
